[sv/npcs_pkg.sv]
// ----------------------------------------------------------------------------
// npcs_pkg: shared types and constants of the nearest palette color search
// Command and status codes, widths and the per-entry struct.
// ----------------------------------------------------------------------------
package npcs_pkg;

  localparam int unsigned PaletteDepthDefault = 256;
  localparam int unsigned DistW = 18;
  localparam logic [DistW-1:0] DistStart = DistW'(3 * 255 * 255 + 1);

  localparam logic [1:0] CmdAdd     = 2'd0;
  localparam logic [1:0] CmdRead    = 2'd1;
  localparam logic [1:0] CmdNearest = 2'd2;
  localparam logic [1:0] CmdUnused  = 2'd3;

  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StFull  = 2'd1;
  localparam logic [1:0] StRange = 2'd2;
  localparam logic [1:0] StEmpty = 2'd3;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // Query travelling along the cell chain together with the running best.
  typedef struct packed {
    logic             valid;
    rgb_t             query;
    logic [DistW-1:0] best_dist;
    logic [7:0]       best_idx;
    rgb_t             best_rgb;
  } probe_t;

  function automatic logic [15:0] sq_diff(input logic [7:0] a, input logic [7:0] b);
    logic [15:0] d;
    d = {8'd0, ((a > b) ? (a - b) : (b - a))};
    return d * d;
  endfunction

endpackage

[sv/nearest_palette_colour_search.sv]
// ----------------------------------------------------------------------------
// nearest_palette_colour_search: palette store with nearest color lookup
// Top level: command decode, count, the chain of palette cells and output.
// ----------------------------------------------------------------------------
// Usage: one command is taken per input transfer (valid_i high, stall_o low).
// Add appends a color, read returns the entry at entry_index_i, nearest
// returns the entry with the least squared RGB distance, lowest index on a
// tie. Every command yields exactly one output transfer on valid_o/stall_i.
// Add, read, unused codes and a nearest on an empty palette finish at once:
// the result is in the output register on the next edge.
// A nearest query travels down the chain of PaletteDepth cells, one cell per
// cycle, and its result is registered in the output register when it leaves
// the last cell. One command is in work at a time.
// Reset empties the palette (the count returns to zero; the entries are
// not cleared and are never read before they are written). While the
// receiver stalls, the output register holds its result and the block takes
// no new command until that result has been transferred.
// ----------------------------------------------------------------------------
module nearest_palette_colour_search #(
  parameter int unsigned PaletteDepth = npcs_pkg::PaletteDepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       stall_o,
  input  logic [1:0] cmd_i,
  input  logic [7:0] red_in_i,
  input  logic [7:0] green_in_i,
  input  logic [7:0] blue_in_i,
  input  logic [7:0] entry_index_i,
  output logic       valid_o,
  input  logic       stall_i,
  output logic [1:0] status_o,
  output logic [7:0] found_index_o,
  output logic [7:0] red_out_o,
  output logic [7:0] green_out_o,
  output logic [7:0] blue_out_o,
  output logic [8:0] entry_count_o
);
  import npcs_pkg::*;

  localparam int unsigned CntW = $clog2(PaletteDepth + 1);

  logic [CntW-1:0] count_q, count_d;
  logic            busy_q, busy_d;   // a nearest query is in the chain
  logic            out_valid_q;
  logic [1:0]      status_q;
  logic [7:0]      idx_q;
  rgb_t            rgb_q;
  logic [8:0]      cnt_out_q;

  logic            accept;
  logic            done_now;
  logic [1:0]      res_status;
  logic [7:0]      res_idx;
  rgb_t            res_rgb;
  rgb_t            in_rgb;

  probe_t          chain   [PaletteDepth+1];
  rgb_t            cell_rgb[PaletteDepth];
  rgb_t            read_rgb;

  assign in_rgb  = '{red: red_in_i, green: green_in_i, blue: blue_in_i};
  assign stall_o = busy_q || out_valid_q;
  assign accept  = valid_i && !stall_o;

  // Probe entering the chain.
  assign chain[0] = '{valid: accept && (cmd_i == CmdNearest) && (count_q != '0),
                      query: in_rgb, best_dist: DistStart, best_idx: '0,
                      best_rgb: '0};

  for (genvar c = 0; c < PaletteDepth; c++) begin : g_cell
    npcs_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .wr_i    (accept && cmd_i == CmdAdd && count_q == CntW'(c)),
      .wr_rgb_i(in_rgb),
      .active_i(CntW'(c) < count_q),
      .idx_i   (8'(c)),
      .probe_i (chain[c]),
      .probe_o (chain[c+1]),
      .rgb_o   (cell_rgb[c])
    );
  end

  // Read port: a constant-depth mux over the cell registers.
  always_comb begin
    read_rgb = '0;
    for (int unsigned k = 0; k < PaletteDepth; k++) begin
      if (entry_index_i == 8'(k)) begin
        read_rgb = cell_rgb[k];
      end
    end
  end

  // Result of a command that completes at once, or of a finished search.
  always_comb begin
    done_now   = 1'b0;
    res_status = StOk;
    res_idx    = '0;
    res_rgb    = '0;
    count_d    = count_q;
    busy_d     = busy_q;
    if (busy_q) begin
      if (chain[PaletteDepth].valid) begin
        done_now = 1'b1;
        busy_d   = 1'b0;
        res_idx  = chain[PaletteDepth].best_idx;
        res_rgb  = chain[PaletteDepth].best_rgb;
      end
    end else if (accept) begin
      unique case (cmd_i)
        CmdAdd: begin
          done_now = 1'b1;
          if (count_q >= CntW'(PaletteDepth)) begin
            res_status = StFull;
          end else begin
            res_idx = 8'(count_q);
            res_rgb = in_rgb;
            count_d = count_q + 1'b1;
          end
        end
        CmdRead: begin
          done_now = 1'b1;
          if (9'(entry_index_i) >= 9'(count_q)) begin
            res_status = StRange;
          end else begin
            res_idx = entry_index_i;
            res_rgb = read_rgb;
          end
        end
        CmdNearest: begin
          if (count_q == '0) begin
            done_now   = 1'b1;
            res_status = StEmpty;
          end else begin
            busy_d = 1'b1;
          end
        end
        default: begin
          done_now = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      busy_q  <= busy_d;
      if (done_now) begin
        out_valid_q <= 1'b1;
      end else if (!stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (done_now) begin
      status_q  <= res_status;
      idx_q     <= res_idx;
      rgb_q     <= res_rgb;
      cnt_out_q <= 9'(count_d);
    end
  end

  assign valid_o       = out_valid_q;
  assign status_o      = status_q;
  assign found_index_o = idx_q;
  assign red_out_o     = rgb_q.red;
  assign green_out_o   = rgb_q.green;
  assign blue_out_o    = rgb_q.blue;
  assign entry_count_o = cnt_out_q;

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(PaletteDepth)) else $error("palette count overflow");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !accept) else $error("command taken during search");
  a_count_only_add: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> $past(accept && cmd_i == CmdAdd))
    else $error("count changed without add");
  a_done_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_now |-> (!out_valid_q || !stall_i)) else $error("result overwritten");

endmodule

[sv/npcs_cell.sv]
// ----------------------------------------------------------------------------
// npcs_cell: one palette slot of the search chain
// Holds one entry, compares it against the passing probe and forwards the
// better of the two to the next cell.
// ----------------------------------------------------------------------------
module npcs_cell (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  npcs_pkg::rgb_t   wr_rgb_i,
  input  logic             active_i,
  input  logic [7:0]       idx_i,
  input  npcs_pkg::probe_t probe_i,
  output npcs_pkg::probe_t probe_o,
  output npcs_pkg::rgb_t   rgb_o
);
  import npcs_pkg::*;

  rgb_t             entry_q;
  logic             valid_q;
  probe_t           probe_q, probe_d;
  logic [DistW-1:0] sq_dist;

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      entry_q <= wr_rgb_i;
    end
  end

  assign sq_dist = DistW'(sq_diff(probe_i.query.red, entry_q.red))
                 + DistW'(sq_diff(probe_i.query.green, entry_q.green))
                 + DistW'(sq_diff(probe_i.query.blue, entry_q.blue));

  always_comb begin
    probe_d = probe_i;
    if (active_i && sq_dist < probe_i.best_dist) begin
      probe_d.best_dist = sq_dist;
      probe_d.best_idx  = idx_i;
      probe_d.best_rgb  = entry_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= probe_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    probe_q <= probe_d;
  end

  always_comb begin
    probe_o       = probe_q;
    probe_o.valid = valid_q;
  end

  assign rgb_o = entry_q;

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench of the nearest palette color search
// Commands are sent from a queue through a random-gap driver, results are
// collected by a randomly stalling monitor and compared field by field with
// the outcome of a behavioral palette kept inside the testbench.
// ----------------------------------------------------------------------------
module tb;
  import npcs_pkg::*;

  localparam int unsigned Depth = 256;
  localparam int unsigned CycleLimit = 2000000;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] index;
  } command_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [8:0] count;
  } answer_t;

  logic       clk_i;
  logic       rst_ni;
  logic       valid_i;
  logic       stall_o;
  logic [1:0] cmd_i;
  logic [7:0] red_in_i;
  logic [7:0] green_in_i;
  logic [7:0] blue_in_i;
  logic [7:0] entry_index_i;
  logic       valid_o;
  logic       stall_i;
  logic [1:0] status_o;
  logic [7:0] found_index_o;
  logic [7:0] red_out_o;
  logic [7:0] green_out_o;
  logic [7:0] blue_out_o;
  logic [8:0] entry_count_o;

  nearest_palette_colour_search dut (.*);

  // Pending commands, the expected answers and the predicted palette contents.
  command_t   pending_cmds[$];
  answer_t    expected_answers[$];
  rgb_t       palette[Depth];
  int unsigned palette_used;
  int unsigned error_count;
  int unsigned cycle_count;
  bit         calm_phase;    // When set, neither side idles.
  bit         hold_sender;   // When set, the driver sends nothing.

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Computes the answer of one command and updates the predicted palette.
  function automatic answer_t palette_answer(input command_t c);
    answer_t a;
    int unsigned best_dist;
    int unsigned sq_dist;
    int unsigned best_i;
    int dr;
    int dg;
    int db;
    a = '0;
    case (c.cmd)
      CmdAdd: begin
        if (palette_used >= Depth) begin
          a.status = StFull;
        end else begin
          palette[palette_used] = '{c.red, c.green, c.blue};
          a.status = StOk;
          a.index = 8'(palette_used);
          {a.red, a.green, a.blue} = {c.red, c.green, c.blue};
          palette_used++;
        end
      end
      CmdRead: begin
        if (c.index >= palette_used) begin
          a.status = StRange;
        end else begin
          a.status = StOk;
          a.index = c.index;
          {a.red, a.green, a.blue} = palette[c.index];
        end
      end
      CmdNearest: begin
        if (palette_used == 0) begin
          a.status = StEmpty;
        end else begin
          best_dist = 3 * 255 * 255 + 1;
          best_i = 0;
          for (int i = 0; i < palette_used; i++) begin
            dr = int'(c.red) - int'(palette[i].red);
            dg = int'(c.green) - int'(palette[i].green);
            db = int'(c.blue) - int'(palette[i].blue);
            sq_dist = dr * dr + dg * dg + db * db;
            if (sq_dist < best_dist) begin
              best_dist = sq_dist;
              best_i = i;
            end
          end
          a.status = StOk;
          a.index = 8'(best_i);
          {a.red, a.green, a.blue} = palette[best_i];
        end
      end
      default: a.status = StOk;   // The unused code leaves the state alone.
    endcase
    a.count = 9'(palette_used);
    return a;
  endfunction

  function automatic command_t make_cmd(input logic [1:0] op, input logic [7:0] r,
                                        input logic [7:0] g, input logic [7:0] b,
                                        input logic [7:0] idx);
    command_t c;
    c = '{op, r, g, b, idx};
    return c;
  endfunction

  // Appends one command to the tail of the pending queue.
  function automatic void queue_cmd(input command_t c);
    pending_cmds = {pending_cmds, c};
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom);
  endfunction

  // Idling decision for one side: idles with a chance of 18 in a hundred, never while calm.
  function automatic bit idle_now();
    return !calm_phase && ($urandom_range(99) < 18);
  endfunction

  // Driver: moves one command from the queue onto the ports per transfer.
  // The payload stays put while stall_o holds the transfer off.
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_i <= 1'b0;
      {cmd_i, red_in_i, green_in_i, blue_in_i, entry_index_i} <= '0;
    end else if (!(valid_i && stall_o)) begin
      if (pending_cmds.size() != 0 && !hold_sender && !idle_now()) begin
        valid_i <= 1'b1;
        {cmd_i, red_in_i, green_in_i, blue_in_i, entry_index_i} <= pending_cmds[0];
      end else begin
        valid_i <= 1'b0;
      end
    end
  end

  // The prediction is made at the edge that accepts the command, so the
  // expected answers line up in acceptance order.
  always @(posedge clk_i) begin
    if (rst_ni && valid_i && !stall_o) begin
      expected_answers = {expected_answers, palette_answer(pending_cmds.pop_front())};
    end
  end

  // Receiver stall, also changed at the falling edge.
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stall_i <= 1'b0;
    end else begin
      stall_i <= idle_now();
    end
  end

  // Monitor: compares each output transfer with the oldest expected answer.
  always @(posedge clk_i) begin
    answer_t got;
    answer_t want;
    if (rst_ni && valid_o && !stall_i) begin
      got = '{status_o, found_index_o, red_out_o, green_out_o, blue_out_o,
              entry_count_o};
      if (expected_answers.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        error_count++;
      end else begin
        want = expected_answers.pop_front();
        if (got.status != want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
          error_count++;
        end
        if (got.index != want.index) begin
          $display("%0t: index expected %0d actual %0d", $time, want.index, got.index);
          error_count++;
        end
        if ({got.red, got.green, got.blue} != {want.red, want.green, want.blue}) begin
          $display("%0t: color expected %h%h%h actual %h%h%h", $time,
                   want.red, want.green, want.blue, got.red, got.green, got.blue);
          error_count++;
        end
        if (got.count != want.count) begin
          $display("%0t: count expected %0d actual %0d", $time, want.count, got.count);
          error_count++;
        end
      end
    end
  end

  // Watchdog: a hang ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb failed");
      $finish;
    end
  end

  // Adds a command mix with random colors. Read indexes are random bytes, so they
  // fall both inside and past the filled part of the palette.
  task automatic queue_random(input int unsigned n, input int unsigned add_pct);
    int unsigned sel;
    logic [1:0] op;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      if (sel < add_pct) op = CmdAdd;
      else if (sel < add_pct + (100 - add_pct) / 3) op = CmdRead;
      else if (sel < 97) op = CmdNearest;
      else op = CmdUnused;
      queue_cmd(make_cmd(op, rand_byte(), rand_byte(), rand_byte(), rand_byte()));
    end
  endtask

  task automatic wait_drained();
    while (pending_cmds.size() != 0 || expected_answers.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    error_count = 0;
    cycle_count = 0;
    palette_used = 0;
    calm_phase = 1'b0;
    hold_sender = 1'b0;
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: the empty palette, the unused code, extreme colors, reads at
    // and past the end, and a tie that must resolve to the lower index.
    queue_cmd(make_cmd(CmdNearest, 8'h00, 8'h00, 8'h00, 8'h00));
    queue_cmd(make_cmd(CmdRead, 8'h00, 8'h00, 8'h00, 8'h00));
    queue_cmd(make_cmd(CmdUnused, 8'hff, 8'hff, 8'hff, 8'hff));
    queue_cmd(make_cmd(CmdAdd, 8'h00, 8'h00, 8'h00, 8'hff));
    queue_cmd(make_cmd(CmdAdd, 8'hff, 8'hff, 8'hff, 8'h00));
    queue_cmd(make_cmd(CmdAdd, 8'h00, 8'h00, 8'h00, 8'h00));
    queue_cmd(make_cmd(CmdAdd, 8'h00, 8'h00, 8'hff, 8'h00));
    queue_cmd(make_cmd(CmdNearest, 8'h80, 8'h80, 8'h80, 8'h00));
    queue_cmd(make_cmd(CmdNearest, 8'h00, 8'h00, 8'h10, 8'h00));
    queue_cmd(make_cmd(CmdNearest, 8'h00, 8'h00, 8'hf0, 8'h00));
    queue_cmd(make_cmd(CmdNearest, 8'hff, 8'hff, 8'hff, 8'h00));
    queue_cmd(make_cmd(CmdRead, 8'h00, 8'h00, 8'h00, 8'd3));
    queue_cmd(make_cmd(CmdRead, 8'h00, 8'h00, 8'h00, 8'd4));
    queue_cmd(make_cmd(CmdRead, 8'h00, 8'h00, 8'h00, 8'hff));
    queue_cmd(make_cmd(CmdUnused, 8'h12, 8'h34, 8'h56, 8'h01));

    // The sender holds off until every answer so far has come back.
    wait_drained();
    hold_sender = 1'b1;
    repeat (20) @(posedge clk_i);
    hold_sender = 1'b0;

    // Random commands while the palette fills; one stretch without idling.
    queue_random(300, 40);
    wait_drained();
    calm_phase = 1'b1;
    queue_random(150, 40);
    wait_drained();
    calm_phase = 1'b0;

    // Fill the palette to the top, then exercise a full palette, including
    // reads of the last entry and adds that must be refused.
    while (palette_used + pending_cmds.size() < Depth) begin
      queue_cmd(make_cmd(CmdAdd, rand_byte(), rand_byte(), rand_byte(), rand_byte()));
    end
    queue_cmd(make_cmd(CmdRead, 8'h00, 8'h00, 8'h00, 8'hff));
    queue_cmd(make_cmd(CmdAdd, 8'h11, 8'h22, 8'h33, 8'h00));
    queue_random(860, 20);
    wait_drained();

    repeat (Depth + 20) @(posedge clk_i);
    if (error_count == 0 && expected_answers.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/npcs_pkg.sv
sv/npcs_cell.sv
sv/nearest_palette_colour_search.sv
tb/sv/tb.sv
